// ===== rtl/core/ffha_pkg.sv =====
`timescale 1ns / 1ps

package ffha_pkg;

  localparam int HEAP_UNITS_DEF = 1024;
  localparam int UNIT_BYTES_DEF = 4;
  localparam int BYTE_W         = 12;
  localparam int UNIT_IDX_W     = 10;
  localparam int STAT_W         = 2;

  // header status codes; allocated, free and end are coded 1, 2 and 3, none is 0
  typedef enum logic [STAT_W-1:0] {
    BLK_NONE  = 2'd0,
    BLK_ALLOC = 2'd1,
    BLK_FREE  = 2'd2,
    BLK_END   = 2'd3
  } blk_stat_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_kind_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_INIT_HEAD,
    CMD_INIT_TAIL,
    CMD_ACCEPT,
    CMD_RD_CUR,
    CMD_RD_HDR,
    CMD_A_SPLIT,
    CMD_A_GRANT,
    CMD_A_NEXT,
    CMD_F_MARK,
    CMD_J_LOAD,
    CMD_J_RD_NXT,
    CMD_J_MERGE,
    CMD_J_ADV,
    CMD_PUSH
  } dp_cmd_t;

  typedef enum logic [3:0] {
    ST_INIT_HEAD,
    ST_INIT_TAIL,
    ST_IDLE,
    ST_A_READ,
    ST_A_EVAL,
    ST_A_GRANT,
    ST_F_READ,
    ST_F_EVAL,
    ST_J_READ,
    ST_J_LOAD,
    ST_J_CHECK,
    ST_J_EVAL,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic rel_ok;
    logic rd_end;
    logic rd_free;
    logic rd_alloc;
    logic fit;
    logic rd_link_ok;
    logic cur_end;
    logic cur_free;
    logic cur_link_ok;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/ffha_ram.sv =====
`timescale 1ns / 1ps

module ffha_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/ffha_dp.sv =====
`timescale 1ns / 1ps

module ffha_dp import ffha_pkg::*; #(
  parameter int HEAP_UNITS = HEAP_UNITS_DEF,
  parameter int UNIT_BYTES = UNIT_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  logic [BYTE_W-1:0]     request_bytes,
  input  logic [UNIT_IDX_W-1:0] release_unit,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [UNIT_IDX_W-1:0] granted_unit,
  output logic                  success
);

  localparam int AW   = $clog2(HEAP_UNITS);
  localparam int RW   = ((AW > UNIT_IDX_W) ? AW : UNIT_IDX_W) + 1;
  localparam int SW   = ((AW > BYTE_W) ? AW : BYTE_W) + 2;
  localparam int RECW = STAT_W + AW;
  localparam logic [AW-1:0] LAST = AW'(HEAP_UNITS - 1);
  localparam int RSH  = 20;
  localparam int PW   = BYTE_W + RSH + 2;
  localparam logic [RSH:0] RECIP =
    (RSH+1)'(((64'd1 << RSH) + 64'(UNIT_BYTES) - 64'd1) / 64'(UNIT_BYTES));

  logic [AW-1:0]         cur;
  logic [AW-1:0]         cur_link;
  blk_stat_t             cur_stat;
  logic [BYTE_W-1:0]     units;
  logic [AW-1:0]         hdr;
  logic [UNIT_IDX_W-1:0] res_unit;
  logic                  res_ok;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [RECW-1:0] ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [RECW-1:0] ram_rdata;

  blk_stat_t         rd_stat;
  logic [AW-1:0]     rd_link;
  logic [BYTE_W:0]   bytes_up;
  logic [PW-1:0]     units_prod;
  logic [BYTE_W-1:0] units_full;
  logic [SW-1:0]     need;
  logic [SW-1:0]     split_full;
  logic [AW-1:0]     split;
  logic [RW-1:0]     gsum;
  logic [RW-1:0]     hdr_full;

  ffha_ram #(
    .WIDTH(RECW),
    .DEPTH(HEAP_UNITS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_stat    = blk_stat_t'(ram_rdata[RECW-1 -: STAT_W]);
  assign rd_link    = ram_rdata[AW-1:0];
  assign bytes_up   = (BYTE_W+1)'(request_bytes) + (BYTE_W+1)'(UNIT_BYTES - 1);
  assign units_prod = PW'(bytes_up) * PW'(RECIP);
  assign units_full = units_prod[RSH +: BYTE_W];
  assign need       = SW'(cur) + SW'(units) + SW'(2);
  assign split_full = SW'(cur) + SW'(units) + SW'(1);
  assign split      = split_full[AW-1:0];
  assign gsum       = RW'(cur) + RW'(1);
  assign hdr_full   = RW'(release_unit) - RW'(1);

  always_comb begin
    status.rel_ok      = (release_unit != '0) && (32'(release_unit) < 32'(HEAP_UNITS));
    status.rd_end      = (rd_stat == BLK_END);
    status.rd_free     = (rd_stat == BLK_FREE);
    status.rd_alloc    = (rd_stat == BLK_ALLOC);
    status.fit         = (SW'(rd_link) >= need);
    status.rd_link_ok  = (32'(rd_link) < 32'(HEAP_UNITS)) && (rd_link > cur);
    status.cur_end     = (cur_stat == BLK_END);
    status.cur_free    = (cur_stat == BLK_FREE);
    status.cur_link_ok = (32'(cur_link) < 32'(HEAP_UNITS)) && (cur_link > cur);
    status.out_free    = !out_valid || out_ready;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur;
    ram_wdata = {BLK_FREE, rd_link};
    ram_re    = 1'b0;
    ram_raddr = cur;
    unique case (cmd)
      CMD_INIT_HEAD: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {BLK_FREE, LAST};
      end
      CMD_INIT_TAIL: begin
        ram_we    = 1'b1;
        ram_waddr = LAST;
        ram_wdata = {BLK_END, {AW{1'b0}}};
      end
      CMD_RD_CUR: begin
        ram_re = 1'b1;
      end
      CMD_RD_HDR: begin
        ram_re    = 1'b1;
        ram_raddr = hdr;
      end
      CMD_A_SPLIT: begin
        ram_we    = 1'b1;
        ram_waddr = split;
        ram_wdata = {BLK_FREE, rd_link};
      end
      CMD_A_GRANT: begin
        ram_we    = 1'b1;
        ram_wdata = {BLK_ALLOC, cur_link};
      end
      CMD_F_MARK: begin
        ram_we    = 1'b1;
        ram_waddr = hdr;
        ram_wdata = {BLK_FREE, rd_link};
      end
      CMD_J_RD_NXT: begin
        ram_re    = 1'b1;
        ram_raddr = cur_link;
      end
      CMD_J_MERGE: begin
        ram_we    = 1'b1;
        ram_wdata = {BLK_FREE, rd_link};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_ACCEPT: begin
        cur      <= '0;
        units    <= units_full;
        hdr      <= hdr_full[AW-1:0];
        res_unit <= '0;
        res_ok   <= 1'b0;
      end
      CMD_A_SPLIT: begin
        cur_link <= split;
      end
      CMD_A_GRANT: begin
        res_unit <= gsum[UNIT_IDX_W-1:0];
        res_ok   <= 1'b1;
      end
      CMD_A_NEXT: begin
        cur <= rd_link;
      end
      CMD_F_MARK: begin
        cur    <= '0;
        res_ok <= 1'b1;
      end
      CMD_J_LOAD: begin
        cur_stat <= rd_stat;
        cur_link <= rd_link;
      end
      CMD_J_MERGE: begin
        cur_link <= rd_link;
      end
      CMD_J_ADV: begin
        cur      <= cur_link;
        cur_stat <= rd_stat;
        cur_link <= rd_link;
      end
      CMD_PUSH: begin
        granted_unit <= res_unit;
        success      <= res_ok;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == CMD_PUSH) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/ffha_ctrl.sv =====
`timescale 1ns / 1ps

module ffha_ctrl import ffha_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       req_type,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT_HEAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    in_ready   = 1'b0;
    unique case (state)
      ST_INIT_HEAD: begin
        cmd        = CMD_INIT_HEAD;
        state_next = ST_INIT_TAIL;
      end
      ST_INIT_TAIL: begin
        cmd        = CMD_INIT_TAIL;
        state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd = CMD_ACCEPT;
          if (req_kind_t'(req_type) == REQ_ALLOC) begin
            state_next = ST_A_READ;
          end else if (status.rel_ok) begin
            state_next = ST_F_READ;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_A_READ: begin
        cmd        = CMD_RD_CUR;
        state_next = ST_A_EVAL;
      end
      ST_A_EVAL: begin
        if (status.rd_end) begin
          state_next = ST_FINISH;
        end else if (status.rd_free && status.fit) begin
          cmd        = CMD_A_SPLIT;
          state_next = ST_A_GRANT;
        end else if (!status.rd_link_ok) begin
          state_next = ST_FINISH;
        end else begin
          cmd        = CMD_A_NEXT;
          state_next = ST_A_READ;
        end
      end
      ST_A_GRANT: begin
        cmd        = CMD_A_GRANT;
        state_next = ST_FINISH;
      end
      ST_F_READ: begin
        cmd        = CMD_RD_HDR;
        state_next = ST_F_EVAL;
      end
      ST_F_EVAL: begin
        if (status.rd_alloc) begin
          cmd        = CMD_F_MARK;
          state_next = ST_J_READ;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_J_READ: begin
        cmd        = CMD_RD_CUR;
        state_next = ST_J_LOAD;
      end
      ST_J_LOAD: begin
        cmd        = CMD_J_LOAD;
        state_next = ST_J_CHECK;
      end
      ST_J_CHECK: begin
        if (status.cur_end || !status.cur_link_ok) begin
          state_next = ST_FINISH;
        end else begin
          cmd        = CMD_J_RD_NXT;
          state_next = ST_J_EVAL;
        end
      end
      ST_J_EVAL: begin
        if (status.rd_end) begin
          state_next = ST_FINISH;
        end else if (status.cur_free && status.rd_free) begin
          cmd        = CMD_J_MERGE;
          state_next = ST_J_CHECK;
        end else begin
          cmd        = CMD_J_ADV;
          state_next = ST_J_CHECK;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd        = CMD_PUSH;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/first_fit_heap_allocator.sv =====
`timescale 1ns / 1ps
// Operation: allocate reads and tests each header in turn from the head, and on a grant
// writes the split header and then the granted one; free reads and marks the header, then
// joins free neighbours from the head, one step per merge or per header passed.
// Throughput: one request at a time; the next word is taken once the result is queued,
// and each step is bound by the one read port of the header memory.
// Reset: INIT_HEAD, INIT_TAIL write head and end headers, in_ready low; out_valid clears.
module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int HEAP_UNITS = HEAP_UNITS_DEF,
  parameter int UNIT_BYTES = UNIT_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  logic [BYTE_W-1:0]     request_bytes,
  input  logic [UNIT_IDX_W-1:0] release_unit,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [UNIT_IDX_W-1:0] granted_unit,
  output logic                  success
);

  dp_cmd_t    cmd;
  dp_status_t status;

  ffha_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .status  (status),
    .cmd     (cmd)
  );

  ffha_dp #(
    .HEAP_UNITS(HEAP_UNITS),
    .UNIT_BYTES(UNIT_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .request_bytes(request_bytes),
    .release_unit (release_unit),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .granted_unit (granted_unit),
    .success      (success)
  );

endmodule

// ===== verif/tb_first_fit_heap_allocator.sv =====
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  localparam int HEAP_UNITS   = HEAP_UNITS_DEF;
  localparam int UNIT_BYTES   = UNIT_BYTES_DEF;
  localparam int LIMIT_CYCLES = 8000000;
  localparam int LONG_HOLD    = 1500;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    req_kind_t             kind;
    logic [UNIT_IDX_W-1:0] unit;
    logic                  ok;
  } heap_result_t;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_RHYTHM} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  req_type = REQ_ALLOC;
  logic [BYTE_W-1:0]     request_bytes = '0;
  logic [UNIT_IDX_W-1:0] release_unit = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [UNIT_IDX_W-1:0] granted_unit;
  logic                  success;

  // header store as the block should hold it
  blk_stat_t hdr_stat [HEAP_UNITS];
  int        hdr_link [HEAP_UNITS];
  bit        hdr_written [HEAP_UNITS];
  int        live_units [$];

  heap_result_t heap_results [$];

  int  cycle_cnt = 0;
  int  err_cnt = 0;
  int  n_grant = 0;
  int  n_refuse = 0;
  int  n_freed = 0;
  int  n_reject = 0;
  int  burst_left = 0;
  bit  last_ok;
  int  hold_reqs = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  mode_left = 0;
  rx_mode_t rx_mode = RX_OPEN;

  first_fit_heap_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .request_bytes(request_bytes),
    .release_unit (release_unit),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .granted_unit (granted_unit),
    .success      (success)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void heap_reset();
    for (int i = 0; i < HEAP_UNITS; i++) begin
      hdr_stat[i]    = BLK_NONE;
      hdr_link[i]    = 0;
      hdr_written[i] = 1'b0;
    end
    hdr_stat[0]                 = BLK_FREE;
    hdr_link[0]                 = HEAP_UNITS - 1;
    hdr_stat[HEAP_UNITS-1]      = BLK_END;
    hdr_written[0]              = 1'b1;
    hdr_written[HEAP_UNITS-1]   = 1'b1;
    live_units.delete();
  endfunction

  function automatic void heap_alloc(input logic [BYTE_W-1:0] bytes,
                                     output logic [UNIT_IDX_W-1:0] unit, output logic ok);
    int need;
    int cur;
    int nxt;
    int gap;
    int split;
    need = (int'(bytes) + UNIT_BYTES - 1) / UNIT_BYTES;
    cur  = 0;
    unit = '0;
    ok   = 1'b0;
    for (int s = 0; s < HEAP_UNITS; s++) begin
      if (hdr_stat[cur] == BLK_END) return;
      nxt = hdr_link[cur];
      gap = nxt - cur - 2;
      if (hdr_stat[cur] == BLK_FREE && gap >= need) begin
        split              = cur + need + 1;
        hdr_stat[split]    = BLK_FREE;
        hdr_link[split]    = nxt;
        hdr_written[split] = 1'b1;
        hdr_stat[cur]      = BLK_ALLOC;
        hdr_link[cur]      = split;
        unit               = UNIT_IDX_W'(cur + 1);
        ok                 = 1'b1;
        live_units.push_back(cur + 1);
        return;
      end
      if (nxt >= HEAP_UNITS || nxt <= cur) return;
      cur = nxt;
    end
  endfunction

  function automatic void heap_join();
    int cur;
    int nxt;
    cur = 0;
    for (int s = 0; s < 2 * HEAP_UNITS; s++) begin
      if (hdr_stat[cur] == BLK_END) return;
      nxt = hdr_link[cur];
      if (nxt >= HEAP_UNITS || nxt <= cur) return;
      if (hdr_stat[nxt] == BLK_END) return;
      if (hdr_stat[cur] == BLK_FREE && hdr_stat[nxt] == BLK_FREE)
        hdr_link[cur] = hdr_link[nxt];
      else
        cur = nxt;
    end
  endfunction

  function automatic logic heap_release(input logic [UNIT_IDX_W-1:0] unit);
    int hdr;
    if (unit == '0) return 1'b0;
    hdr = int'(unit) - 1;
    if (hdr_stat[hdr] != BLK_ALLOC) return 1'b0;
    hdr_stat[hdr] = BLK_FREE;
    heap_join();
    for (int i = 0; i < live_units.size(); i++) begin
      if (live_units[i] == int'(unit)) begin
        live_units.delete(i);
        break;
      end
    end
    return 1'b1;
  endfunction

  // only headers that were written, or unit 0, may be named by a free
  function automatic logic [UNIT_IDX_W-1:0] pick_release_target();
    int roll;
    int u;
    roll = $urandom_range(0, 99);
    if (live_units.size() != 0 && roll < 85)
      return UNIT_IDX_W'(live_units[$urandom_range(0, live_units.size() - 1)]);
    if (roll < 90) return '0;
    for (int t = 0; t < 32; t++) begin
      u = $urandom_range(1, HEAP_UNITS - 1);
      if (hdr_written[u-1]) return UNIT_IDX_W'(u);
    end
    return '0;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_request_bytes();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return BYTE_W'($urandom_range(0, 63));
    if (roll < 85) return BYTE_W'($urandom_range(64, 1023));
    return BYTE_W'($urandom_range(0, 4095));
  endfunction

  task automatic send_word(input req_kind_t kind, input logic [BYTE_W-1:0] bytes,
                           input logic [UNIT_IDX_W-1:0] unit);
    int gap;
    heap_result_t exp_res;
    logic [UNIT_IDX_W-1:0] g_unit;
    logic g_ok;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid      <= 1'b1;
    req_type      <= kind;
    request_bytes <= bytes;
    release_unit  <= unit;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exp_res.kind = kind;
    if (kind == REQ_ALLOC) begin
      heap_alloc(bytes, g_unit, g_ok);
      exp_res.unit = g_unit;
      exp_res.ok   = g_ok;
    end else begin
      exp_res.unit = '0;
      exp_res.ok   = heap_release(unit);
    end
    last_ok = exp_res.ok;
    heap_results.push_back(exp_res);
  endtask

  task automatic send_alloc(input logic [BYTE_W-1:0] bytes);
    send_word(REQ_ALLOC, bytes, UNIT_IDX_W'($urandom));
  endtask

  task automatic send_free(input logic [UNIT_IDX_W-1:0] unit);
    send_word(REQ_FREE, BYTE_W'($urandom), unit);
  endtask

  task automatic send_random_word();
    if (live_units.size() == 0 || $urandom_range(0, 99) < 55)
      send_alloc(pick_request_bytes());
    else
      send_free(pick_release_target());
  endtask

  task automatic test_directed();
    send_alloc(12'd4095);
    send_alloc(12'd4088);
    send_alloc(12'd4085);
    send_alloc(12'd4084);
    send_alloc(12'd0);
    send_free(10'd0);
    send_free(10'd1);
    send_free(10'd1);
    send_free(10'd1023);
    send_alloc(12'd0);
    send_alloc(12'd0);
    send_alloc(12'd1);
    send_alloc(12'd4);
    send_alloc(12'd5);
    send_free(10'd3);
    send_free(10'd5);
    send_free(10'd2);
    send_free(10'd5);
    send_alloc(12'd8);
    send_free(10'd1);
    send_free(10'd7);
  endtask

  task automatic test_fill_and_drain();
    last_ok = 1'b1;
    for (int i = 0; i < 60 && last_ok; i++) send_alloc(BYTE_W'($urandom_range(150, 250)));
    while (live_units.size() != 0)
      send_free(UNIT_IDX_W'(live_units[$urandom_range(0, live_units.size() - 1)]));
  endtask

  task automatic test_backpressure();
    hold_reqs <= hold_reqs + 1;
    repeat (40) send_random_word();
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_random_word();
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("%0t timeout with %0d results outstanding", $time, heap_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 400);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN:  out_ready <= 1'b1;
        RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
        default:  out_ready <= ((cycle_cnt % 7) < 2);
      endcase
    end
  end

  always @(posedge clk) begin
    heap_result_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (heap_results.size() == 0) begin
        $display("%0t unexpected word: expected none, actual unit %0d success %0b",
                 $time, granted_unit, success);
        err_cnt++;
      end else begin
        exp_res = heap_results.pop_front();
        if (granted_unit !== exp_res.unit) begin
          $display("%0t granted_unit mismatch: expected %0d actual %0d",
                   $time, exp_res.unit, granted_unit);
          err_cnt++;
        end
        if (success !== exp_res.ok) begin
          $display("%0t success mismatch: expected %0b actual %0b",
                   $time, exp_res.ok, success);
          err_cnt++;
        end
        if (exp_res.kind == REQ_ALLOC) begin
          if (exp_res.ok) n_grant++;
          else n_refuse++;
        end else begin
          if (exp_res.ok) n_freed++;
          else n_reject++;
        end
      end
    end
  end

  initial begin
    heap_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_fill_and_drain();
    test_backpressure();
    test_random_mix(1060);
    in_valid <= 1'b0;
    while (heap_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d allocations granted and %0d refused,", n_grant, n_refuse);
    $display("%0d frees accepted and %0d rejected, %0d mismatches.", n_freed, n_reject,
             err_cnt);
    if (err_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== first_fit_heap_allocator.f =====
rtl/core/ffha_pkg.sv
rtl/core/ffha_ram.sv
rtl/core/ffha_dp.sv
rtl/core/ffha_ctrl.sv
rtl/core/first_fit_heap_allocator.sv
verif/tb_first_fit_heap_allocator.sv
